// ----- hdl/btn_dbnc_pkg.sv -----
// Shared constants for the button debounce / press classifier.
`timescale 1ns / 1ps

package btn_dbnc_pkg;

  // Width of the threshold configuration registers
  localparam int THRESH_W = 16;

  // Per-button phase codes
  localparam logic [1:0] PHASE_IDLE     = 2'd0;
  localparam logic [1:0] PHASE_DEBOUNCE = 2'd1;
  localparam logic [1:0] PHASE_PRESSED  = 2'd2;
  localparam logic [1:0] PHASE_HOLD     = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_SHORT_MAX  = 2'd2;
  localparam logic [1:0] REG_EVENT_ENA  = 2'd3;

  // Register reset values
  localparam logic [THRESH_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [THRESH_W-1:0] LONG_PRESS_RST = 16'd800;
  localparam logic [THRESH_W-1:0] SHORT_MAX_RST  = 16'd500;

  typedef logic [THRESH_W-1:0] thresh_t;

endpackage

// ----- hdl/button_debounce_short_long_press.sv -----
// Button debounce with short / long press classification, top level.
//
// Usage:
//   Each input transaction on the in_ channel is one tick and carries the raw
//   active-low levels of all buttons (bit i = button i, 0 = pressed). Every
//   accepted tick produces exactly one output transaction on the out_ channel:
//   per-button short and long press events (masked by the event enable
//   register) and the 32-bit running tick count after this tick.
//   The phase machines, the tick counter and the output register all update
//   at the accepting edge, and the result is seen the cycle after the accept.
//   Throughput is one tick per cycle while the receiver does not stall; the
//   update per button is an increment and a compare, all buttons in parallel.
//   While the output register holds a result the receiver stalls, in_stall is
//   raised and no new tick is taken, so nothing is lost or repeated.
//   Reset (rst_n low, synchronous) puts every button in idle, clears timers
//   and the tick count, empties the output register and loads the register
//   defaults: debounce 20, long press 800, short max 500, events disabled.
//   The user must write the APB-style port (4-byte registers) only while idle;
//   the block itself does not enforce this. pready is tied high.
`timescale 1ns / 1ps

module button_debounce_short_long_press #(
  parameter int NUM_BUTTONS = 2,
  parameter int TIMER_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // tick input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [NUM_BUTTONS-1:0] in_key_levels,
  // event output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [NUM_BUTTONS-1:0] out_short_press,
  output logic [NUM_BUTTONS-1:0] out_long_press,
  output logic [31:0]            out_elapsed_ticks,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Compare width covers both the timer and the 16-bit thresholds
  localparam int CMP_W = (TIMER_BITS > btn_dbnc_pkg::THRESH_W) ?
                         TIMER_BITS : btn_dbnc_pkg::THRESH_W;

  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [TIMER_BITS-1:0] timer_t;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  btn_dbnc_pkg::thresh_t  debounce_r;
  btn_dbnc_pkg::thresh_t  long_press_r;
  btn_dbnc_pkg::thresh_t  short_max_r;
  logic [NUM_BUTTONS-1:0] event_ena_r;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= btn_dbnc_pkg::DEBOUNCE_RST;
      long_press_r <= btn_dbnc_pkg::LONG_PRESS_RST;
      short_max_r  <= btn_dbnc_pkg::SHORT_MAX_RST;
      event_ena_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        btn_dbnc_pkg::REG_DEBOUNCE:   debounce_r   <= pwdata[btn_dbnc_pkg::THRESH_W-1:0];
        btn_dbnc_pkg::REG_LONG_PRESS: long_press_r <= pwdata[btn_dbnc_pkg::THRESH_W-1:0];
        btn_dbnc_pkg::REG_SHORT_MAX:  short_max_r  <= pwdata[btn_dbnc_pkg::THRESH_W-1:0];
        btn_dbnc_pkg::REG_EVENT_ENA:  event_ena_r  <= pwdata[NUM_BUTTONS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      btn_dbnc_pkg::REG_DEBOUNCE:   prdata = 32'(debounce_r);
      btn_dbnc_pkg::REG_LONG_PRESS: prdata = 32'(long_press_r);
      btn_dbnc_pkg::REG_SHORT_MAX:  prdata = 32'(short_max_r);
      btn_dbnc_pkg::REG_EVENT_ENA:  prdata = 32'(event_ena_r);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Handshake: output register parts the two channels
  // ---------------------------------------------------------------
  logic in_acc;
  logic out_valid_r;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Per-button phase machines
  // ---------------------------------------------------------------
  logic [1:0]             phase_r   [NUM_BUTTONS];
  logic [1:0]             phase_nxt [NUM_BUTTONS];
  timer_t                 timer_r   [NUM_BUTTONS];
  timer_t                 timer_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] short_ev;
  logic [NUM_BUTTONS-1:0] long_ev;
  logic [31:0]            tick_r;
  logic [NUM_BUTTONS-1:0] short_r;
  logic [NUM_BUTTONS-1:0] long_r;

  always_comb begin
    timer_t tinc;
    logic   down;
    short_ev = '0;
    long_ev  = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      down         = ~in_key_levels[i];
      // saturating increment
      tinc         = (timer_r[i] == '1) ? timer_r[i] : timer_r[i] + 1'b1;
      phase_nxt[i] = phase_r[i];
      timer_nxt[i] = timer_r[i];
      case (phase_r[i])
        btn_dbnc_pkg::PHASE_IDLE: begin
          if (down) begin
            phase_nxt[i] = btn_dbnc_pkg::PHASE_DEBOUNCE;
            timer_nxt[i] = '0;
          end
        end
        btn_dbnc_pkg::PHASE_DEBOUNCE: begin
          if (down) begin
            if (cmp_t'(tinc) >= cmp_t'(debounce_r)) begin
              phase_nxt[i] = btn_dbnc_pkg::PHASE_PRESSED;
              timer_nxt[i] = '0;
            end else begin
              timer_nxt[i] = tinc;
            end
          end else begin
            // timer keeps its value on a bounce back to idle
            phase_nxt[i] = btn_dbnc_pkg::PHASE_IDLE;
          end
        end
        btn_dbnc_pkg::PHASE_PRESSED: begin
          if (down) begin
            timer_nxt[i] = tinc;
            if (cmp_t'(tinc) >= cmp_t'(long_press_r)) begin
              long_ev[i]   = 1'b1;
              phase_nxt[i] = btn_dbnc_pkg::PHASE_HOLD;
            end
          end else begin
            short_ev[i]  = cmp_t'(timer_r[i]) < cmp_t'(short_max_r);
            phase_nxt[i] = btn_dbnc_pkg::PHASE_IDLE;
          end
        end
        default: begin
          if (!down) begin
            phase_nxt[i] = btn_dbnc_pkg::PHASE_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        phase_r[i] <= btn_dbnc_pkg::PHASE_IDLE;
        timer_r[i] <= '0;
      end
      tick_r <= '0;
    end else if (in_acc) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        phase_r[i] <= phase_nxt[i];
        timer_r[i] <= timer_nxt[i];
      end
      tick_r <= tick_r + 32'd1;
    end
  end

  // Result payload; the tick count only moves on an accept, so it doubles
  // as the elapsed count field of the held result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      short_r <= short_ev & event_ena_r;
      long_r  <= long_ev & event_ena_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_short_press   = short_r;
  assign out_long_press    = long_r;
  assign out_elapsed_ticks = tick_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_no_short_and_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_short_press & out_long_press) == '0))
    else $error("short and long event on the same button");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_valid && out_elapsed_ticks == $past(out_elapsed_ticks) + 32'd1))
    else $error("tick count did not advance by one per accepted tick");

  a_long_enters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && long_ev[0]) |=> (phase_r[0] == btn_dbnc_pkg::PHASE_HOLD))
    else $error("long event without entering hold");

endmodule
